>>> rtl/hst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hst_pkg
// Shared constants, codes and types for the handle slot table.
// ----------------------------------------------------------------------------
package hst_pkg;

  // Table geometry (SLOTS must be a power of two)
  localparam int SLOTS        = 256;
  localparam int SLOT_W       = $clog2(SLOTS);
  localparam int CONTEXT_BITS = 16;

  // Fixed field widths
  localparam int OP_W     = 2;
  localparam int HANDLE_W = 24;
  localparam int CTX_W    = 16;
  localparam int STATUS_W = 2;

  // Context bits actually kept in a slot
  localparam int CTX_STORE_W = (CONTEXT_BITS < CTX_W) ? CONTEXT_BITS : CTX_W;

  // Handle limits; handle zero is reserved
  localparam logic [HANDLE_W-1:0] HANDLE_MAX = 24'hFFFFFF;
  localparam logic [HANDLE_W-1:0] HANDLE_MIN = 24'd1;

  // Operation codes
  localparam logic [OP_W-1:0] OP_REGISTER = 2'd0;
  localparam logic [OP_W-1:0] OP_RETIRE   = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP   = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

  // One slot of the table memory
  typedef struct packed {
    logic [HANDLE_W-1:0]    handle;
    logic [CTX_STORE_W-1:0] ctx;
  } slot_entry_t;

endpackage

>>> rtl/handle_slot_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// handle_slot_table
// Direct-mapped table that hands out 24-bit handles, retires them and looks
// up the context stored with a handle.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                                          Handshake
//  --------  ---------------------------------------------  ----------------
//  request   operation_i, handle_in_i, context_id_i         start && !busy
//  result    status_o, handle_out_o, context_out_o          done_o (1 cycle)
//
//  Retire and lookup do one registered slot memory read, then a tag
//  compare. Register probes 1 to SLOTS slots: the probe loop tests one
//  valid bit per cycle through a single incrementer. busy stays high from
//  acceptance and drops in the cycle the result strobe appears. Reset
//  frees every slot at once (valid flops) and sets the seed to 1. The
//  receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module handle_slot_table (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [hst_pkg::OP_W-1:0]       operation_i,
  input  logic [hst_pkg::HANDLE_W-1:0]   handle_in_i,
  input  logic [hst_pkg::CTX_W-1:0]      context_id_i,
  output logic                           done_o,
  output logic [hst_pkg::STATUS_W-1:0]   status_o,
  output logic [hst_pkg::HANDLE_W-1:0]   handle_out_o,
  output logic [hst_pkg::CTX_W-1:0]      context_out_o
);
  import hst_pkg::*;

  // Sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PROBE = 2'd1;
  localparam logic [1:0] S_CHECK = 2'd2;

  logic [1:0]              state_q, state_d;
  logic [OP_W-1:0]         op_q;
  logic [HANDLE_W-1:0]     hin_q;
  logic [CTX_STORE_W-1:0]  ctx_q;
  logic [HANDLE_W-1:0]     probe_q, probe_d;
  logic [SLOT_W-1:0]       cnt_q, cnt_d;
  logic [HANDLE_W-1:0]     seed_q, seed_d;
  logic [SLOTS-1:0]        valid_q, valid_d;

  logic                    done_d;
  logic [STATUS_W-1:0]     status_d;
  logic [HANDLE_W-1:0]     hout_d;
  logic [CTX_W-1:0]        cout_d;

  logic                    accept;
  logic                    wr_en;
  logic [SLOT_W-1:0]       probe_idx;
  logic [SLOT_W-1:0]       hin_idx;
  logic [HANDLE_W-1:0]     probe_next;
  logic                    hit;

  slot_entry_t             mem [SLOTS];
  slot_entry_t             rd_q;
  slot_entry_t             wr_entry;

  assign accept    = start && !busy;
  assign busy      = (state_q != S_IDLE);
  assign probe_idx = probe_q[SLOT_W-1:0];
  assign hin_idx   = hin_q[SLOT_W-1:0];

  // Shared incrementer: next handle, skipping reserved zero
  assign probe_next = (probe_q == HANDLE_MAX) ? HANDLE_MIN : probe_q + HANDLE_W'(1);

  // Tag compare for retire and lookup
  assign hit = ((op_q == OP_RETIRE) || (op_q == OP_LOOKUP)) &&
               valid_q[hin_idx] && (rd_q.handle == hin_q);

  assign wr_entry.handle = probe_q;
  assign wr_entry.ctx    = ctx_q;

  // Sequencer
  always_comb begin
    state_d  = state_q;
    probe_d  = probe_q;
    cnt_d    = cnt_q;
    seed_d   = seed_q;
    valid_d  = valid_q;
    wr_en    = 1'b0;
    done_d   = 1'b0;
    status_d = ST_NOTFOUND;
    hout_d   = '0;
    cout_d   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          probe_d = seed_q;
          cnt_d   = '0;
          state_d = (operation_i == OP_REGISTER) ? S_PROBE : S_CHECK;
        end
      end
      S_PROBE: begin
        if (!valid_q[probe_idx]) begin
          wr_en              = 1'b1;
          valid_d[probe_idx] = 1'b1;
          seed_d             = probe_next;
          done_d             = 1'b1;
          status_d           = ST_DONE;
          hout_d             = probe_q;
          state_d            = S_IDLE;
        end else if (cnt_q == SLOT_W'(SLOTS - 1)) begin
          done_d   = 1'b1;
          status_d = ST_FULL;
          state_d  = S_IDLE;
        end else begin
          probe_d = probe_next;
          cnt_d   = cnt_q + SLOT_W'(1);
        end
      end
      S_CHECK: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
        if (hit) begin
          status_d = ST_DONE;
          if (op_q == OP_RETIRE) begin
            valid_d[hin_idx] = 1'b0;
          end else begin
            cout_d = CTX_W'(rd_q.ctx);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      seed_q  <= HANDLE_MIN;
      valid_q <= '0;
      done_o  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      seed_q  <= seed_d;
      valid_q <= valid_d;
      done_o  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  // Transaction payload and result registers
  always_ff @(posedge clk_i) begin
    probe_q <= probe_d;
    if (accept) begin
      op_q  <= operation_i;
      hin_q <= handle_in_i;
      ctx_q <= context_id_i[CTX_STORE_W-1:0];
    end
    if (done_d) begin
      status_o      <= status_d;
      handle_out_o  <= hout_d;
      context_out_o <= cout_d;
    end
  end

  // Slot memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[probe_idx] <= wr_entry;
    end
    if (accept) begin
      rd_q <= mem[handle_in_i[SLOT_W-1:0]];
    end
  end

  // Assertions
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result strobe without a transaction in flight");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_seed_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seed_q != '0)
    else $error("handle seed reached reserved zero");

  a_full_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_FULL)) |-> (handle_out_o == '0) && (context_out_o == '0))
    else $error("table full result carries data");

endmodule
